// ===== hw/rtl/lsrc_pkg.sv =====
// lsrc_pkg: shared types and constants for the segment clipper
// no dependencies
package lsrc_pkg;

	localparam int COORD_W   = 32;
	localparam int DIV_STEPS = 32;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		CFG_X_MIN = 2'd0,
		CFG_X_MAX = 2'd1,
		CFG_Y_MIN = 2'd2,
		CFG_Y_MAX = 2'd3
	} cfg_idx_t;

	// one segment in flight: a is the ordering axis of the current pass
	typedef struct packed {
		logic   valid;
		logic   empty;
		logic   par;
		coord_t a1;
		coord_t a2;
		coord_t c1;
		coord_t c2;
	} pass_item_t;

endpackage

// ===== hw/rtl/lsrc_if.sv =====
// lsrc_seg_if and lsrc_res_if: segment and result channels
// depends on lsrc_pkg
interface lsrc_seg_if;
	import lsrc_pkg::*;
	logic   valid;
	logic   ready;
	coord_t start_x;
	coord_t start_y;
	coord_t end_x;
	coord_t end_y;
	modport source(output valid, start_x, start_y, end_x, end_y, input ready);
	modport sink(input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lsrc_res_if;
	import lsrc_pkg::*;
	logic   valid;
	logic   ready;
	logic   is_empty;
	coord_t clip_start_x;
	coord_t clip_start_y;
	coord_t clip_end_x;
	coord_t clip_end_y;
	modport source(output valid, is_empty, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, input ready);
	modport sink(input valid, is_empty, clip_start_x, clip_start_y, clip_end_x,
		clip_end_y, output ready);
endinterface

// ===== hw/rtl/lsrc_pass.sv =====
// lsrc_pass: one clip pass (order, reject, interpolate both ends), 35 stages
// depends on lsrc_pkg
module lsrc_pass (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  lsrc_pkg::coord_t    lo,
	input  lsrc_pkg::coord_t    hi,
	input  lsrc_pkg::pass_item_t din,
	output lsrc_pkg::pass_item_t dout
);
	import lsrc_pkg::*;

	typedef struct packed {
		pass_item_t  it;
		logic        mv1;
		logic        mv2;
		logic        neg;
		logic [31:0] m;
		logic [31:0] d;
		logic [31:0] t1;
		logic [31:0] t2;
	} ord_t;

	typedef struct packed {
		pass_item_t  it;
		logic        mv1;
		logic        mv2;
		logic        neg;
		logic [31:0] d;
		logic [63:0] n1;
		logic [63:0] n2;
	} dstage_t;

	// one restoring step: remainder in the upper half, quotient shifts in below
	function automatic logic [63:0] div_step(input logic [63:0] n, input logic [31:0] d);
		logic [32:0] tmp;
		logic [32:0] rem;
		logic        ge;
		tmp = n[63:31];
		ge  = (tmp >= {1'b0, d});
		rem = ge ? (tmp - {1'b0, d}) : tmp;
		return {rem[31:0], n[30:0], ge};
	endfunction

	function automatic coord_t add_sat(input coord_t c, input logic neg, input logic [31:0] q);
		logic signed [33:0] s;
		s = neg ? ({{2{c[31]}}, c} - $signed({2'b00, q}))
		        : ({{2{c[31]}}, c} + $signed({2'b00, q}));
		if (s > 34'sh0_7FFF_FFFF)
			return 32'sh7FFF_FFFF;
		else if (s < -34'sh0_8000_0000)
			return 32'sh8000_0000;
		else
			return s[31:0];
	endfunction

	ord_t             ord_d;
	ord_t             ord_s1;
	dstage_t          mul_d;
	dstage_t          div_s [DIV_STEPS+1];
	pass_item_t       fin_d;

	// stage 1: order by a, reject, set up magnitudes
	always_comb begin
		logic              swap;
		logic              ok;
		logic signed [32:0] dc;
		logic signed [32:0] da;
		logic signed [32:0] ndc;
		coord_t            a1, a2, c1, c2;
		swap = din.a1 > din.a2;
		a1   = swap ? din.a2 : din.a1;
		a2   = swap ? din.a1 : din.a2;
		c1   = swap ? din.c2 : din.c1;
		c2   = swap ? din.c1 : din.c2;
		ok   = !din.empty && !(a2 < lo || a1 > hi);
		dc   = {c2[31], c2} - {c1[31], c1};
		da   = {a2[31], a2} - {a1[31], a1};
		ndc  = -dc;
		ord_d.it    = '{valid: din.valid, empty: !ok, par: din.par ^ swap,
		                a1: a1, a2: a2, c1: c1, c2: c2};
		ord_d.mv1   = ok && (a1 < lo);
		ord_d.mv2   = ok && (a2 > hi);
		ord_d.neg   = dc[32];
		ord_d.m     = dc[32] ? ndc[31:0] : dc[31:0];
		ord_d.d     = da[31:0];
		ord_d.t1    = lo - a1;
		ord_d.t2    = hi - a1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ord_s1.it.valid <= 1'b0;
		end else if (en) begin
			ord_s1 <= ord_d;
		end
	end

	// stage 2: the two products
	always_comb begin
		mul_d.it  = ord_s1.it;
		mul_d.mv1 = ord_s1.mv1;
		mul_d.mv2 = ord_s1.mv2;
		mul_d.neg = ord_s1.neg;
		mul_d.d   = ord_s1.d;
		mul_d.n1  = 64'(ord_s1.m) * 64'(ord_s1.t1);
		mul_d.n2  = 64'(ord_s1.m) * 64'(ord_s1.t2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			div_s[0].it.valid <= 1'b0;
		end else if (en) begin
			div_s[0] <= mul_d;
		end
	end

	// one quotient bit per stage for both ends
	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
		dstage_t nxt;
		always_comb begin
			nxt    = div_s[k];
			nxt.n1 = div_step(div_s[k].n1, div_s[k].d);
			nxt.n2 = div_step(div_s[k].n2, div_s[k].d);
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_s[k+1].it.valid <= 1'b0;
			end else if (en) begin
				div_s[k+1] <= nxt;
			end
		end
	end

	// last stage: move ends onto the bounds
	always_comb begin
		fin_d    = div_s[DIV_STEPS].it;
		if (div_s[DIV_STEPS].mv1) begin
			fin_d.a1 = lo;
			fin_d.c1 = add_sat(div_s[DIV_STEPS].it.c1, div_s[DIV_STEPS].neg,
				div_s[DIV_STEPS].n1[31:0]);
		end
		if (div_s[DIV_STEPS].mv2) begin
			fin_d.a2 = hi;
			fin_d.c2 = add_sat(div_s[DIV_STEPS].it.c1, div_s[DIV_STEPS].neg,
				div_s[DIV_STEPS].n2[31:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dout.valid <= 1'b0;
		end else if (en) begin
			dout <= fin_d;
		end
	end

endmodule

// ===== hw/rtl/line_segment_rect_clip.sv =====
// line_segment_rect_clip: clips one segment to the configured rectangle
// accepts one segment per cycle while no result waits untaken
// pipe depth set by the 32-stage restoring dividers in each of the two passes
// the whole pipe advances together; it halts only while a result waits untaken
// reset clears all valid bits and loads the full-range rectangle
// depends on lsrc_pkg, lsrc_if, lsrc_pass
module line_segment_rect_clip (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  lsrc_pkg::cfg_idx_t cfg_idx,
	input  lsrc_pkg::coord_t   cfg_data,
	lsrc_seg_if.sink           seg,
	lsrc_res_if.source         res
);
	import lsrc_pkg::*;

	coord_t     x_min_q, x_max_q, y_min_q, y_max_q;
	logic       en;
	pass_item_t px_in, px_out, py_in, py_out;

	// clip rectangle registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_min_q <= 32'sh8000_0000;
			x_max_q <= 32'sh7FFF_FFFF;
			y_min_q <= 32'sh8000_0000;
			y_max_q <= 32'sh7FFF_FFFF;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_X_MIN: x_min_q <= cfg_data;
				CFG_X_MAX: x_max_q <= cfg_data;
				CFG_Y_MIN: y_min_q <= cfg_data;
				CFG_Y_MAX: y_max_q <= cfg_data;
				default:   ;
			endcase
		end
	end

	// whole pipe moves when the output register is free or being drained
	assign en        = !res.valid || res.ready;
	assign seg.ready = en;

	// x pass: ordering axis x, interpolated axis y
	assign px_in = '{valid: seg.valid, empty: 1'b0, par: 1'b0,
	                 a1: seg.start_x, a2: seg.end_x, c1: seg.start_y, c2: seg.end_y};

	lsrc_pass u_pass_x (
		.clk, .arst_n, .en,
		.lo(x_min_q), .hi(x_max_q),
		.din(px_in), .dout(px_out)
	);

	// y pass: roles exchanged
	assign py_in = '{valid: px_out.valid, empty: px_out.empty, par: px_out.par,
	                 a1: px_out.c1, a2: px_out.c2, c1: px_out.a1, c2: px_out.a2};

	lsrc_pass u_pass_y (
		.clk, .arst_n, .en,
		.lo(y_min_q), .hi(y_max_q),
		.din(py_in), .dout(py_out)
	);

	// final x order and reject, then restore original direction
	logic   f_swap, f_ok, f_par;
	coord_t fx1, fx2, fy1, fy2;

	always_comb begin
		f_swap = py_out.c1 > py_out.c2;
		fx1    = f_swap ? py_out.c2 : py_out.c1;
		fx2    = f_swap ? py_out.c1 : py_out.c2;
		fy1    = f_swap ? py_out.a2 : py_out.a1;
		fy2    = f_swap ? py_out.a1 : py_out.a2;
		f_ok   = !py_out.empty && !(fx2 < x_min_q || fx1 > x_max_q);
		f_par  = py_out.par ^ f_swap;
	end

	// output register, holds while the sink stalls
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res.valid <= 1'b0;
		end else if (en) begin
			res.valid        <= py_out.valid;
			res.is_empty     <= !f_ok;
			res.clip_start_x <= !f_ok ? '0 : (f_par ? fx2 : fx1);
			res.clip_start_y <= !f_ok ? '0 : (f_par ? fy2 : fy1);
			res.clip_end_x   <= !f_ok ? '0 : (f_par ? fx1 : fx2);
			res.clip_end_y   <= !f_ok ? '0 : (f_par ? fy1 : fy2);
		end
	end

	// rejected transaction carries zero coordinates
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.is_empty |-> res.clip_start_x == 0 && res.clip_start_y == 0
			&& res.clip_end_x == 0 && res.clip_end_y == 0)
		else $error("empty result with nonzero coordinates");

	// kept y coordinates lie in the y range of a proper rectangle
	a_y_range: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.is_empty && y_min_q <= y_max_q |->
			res.clip_start_y >= y_min_q && res.clip_start_y <= y_max_q
			&& res.clip_end_y >= y_min_q && res.clip_end_y <= y_max_q)
		else $error("clipped y outside rectangle");

	// input is held back only by a waiting result
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!seg.ready |-> res.valid && !res.ready)
		else $error("input stalled without output backpressure");

endmodule
